/* hdl/lrc_pkg.sv */
// lrc_pkg: shared constants and types for the ROM bank cache tag engine.
// Used by lrc_scan and lru_rom_bank_cache; no dependencies.
`timescale 1ns / 1ps

package lrc_pkg;

   localparam int CSR_W   = 10;   // bank_count register width
   localparam int STAMP_W = 32;   // use clock and slot stamp width
   localparam int TOTAL_W = 32;   // hit and miss counter width

   localparam logic [CSR_W-1:0] CSR_RESET = CSR_W'(2);

   // Control from the sequencer to the slot scan unit
   typedef struct packed {
      logic clear;    // new lookup: drop previous search results
      logic sample;   // read data of one slot is on the RAM output
   } lrc_scan_ctrl_type;

endpackage

/* hdl/lrc_ram.sv */
// lrc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/lrc_scan.sv */
// lrc_scan: walks slot entries as they come out of the slot RAM, one per cycle,
// tracking the first tag match and the oldest stamp. Depends on lrc_pkg.
`timescale 1ns / 1ps

module lrc_scan #(
   parameter int BANK_BITS = 9,
   parameter int IDX_W     = 3
) (
   input  logic                          clock,
   input  lrc_pkg::lrc_scan_ctrl_type    ctrl,
   input  logic [BANK_BITS-1:0]          bank,
   input  logic [IDX_W-1:0]              entry_idx,
   input  logic                          entry_valid,
   input  logic [BANK_BITS-1:0]          entry_tag,
   input  logic [lrc_pkg::STAMP_W-1:0]   entry_stamp,
   output logic                          found,
   output logic [IDX_W-1:0]              found_idx,
   output logic [IDX_W-1:0]              victim_idx
);

   import lrc_pkg::*;

   logic               found_ff, found_in;
   logic [IDX_W-1:0]   found_idx_ff, found_idx_in;
   logic [IDX_W-1:0]   victim_idx_ff, victim_idx_in;
   logic [STAMP_W-1:0] oldest_ff, oldest_in;
   logic [STAMP_W-1:0] stamp_eff;

   // an empty slot counts as stamp zero
   assign stamp_eff = entry_valid ? entry_stamp : '0;

   always_comb begin
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      victim_idx_in = victim_idx_ff;
      oldest_in     = oldest_ff;
      if (ctrl.clear) begin
         found_in      = 1'b0;
         found_idx_in  = '0;
         victim_idx_in = '0;
         oldest_in     = '1;
      end else if (ctrl.sample) begin
         if (!found_ff && entry_valid && entry_tag == bank) begin
            found_in     = 1'b1;
            found_idx_in = entry_idx;
         end
         // strict compare keeps the lowest slot on ties
         if (stamp_eff < oldest_ff) begin
            oldest_in     = stamp_eff;
            victim_idx_in = entry_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      victim_idx_ff <= victim_idx_in;
      oldest_ff     <= oldest_in;
   end

   assign found      = found_ff;
   assign found_idx  = found_idx_ff;
   assign victim_idx = victim_idx_ff;

endmodule

/* hdl/lru_rom_bank_cache.sv */
// lru_rom_bank_cache: tag and LRU engine for banked cartridge ROM (lrc_pkg, lrc_ram, lrc_scan).
// A non-zero bank reads every slot through the single slot RAM read port in turn (ST_SCAN),
// waits for the last read data (ST_DRAIN) and updates the slot (ST_UPDATE); bank 0 uses ST_FIXED.
// A new request is taken only after the previous one is answered, as req_tready is high only in
// ST_IDLE; a stalled response holds the engine in its final state.
// Reset (synchronous): all slots empty, use clock and counters zero, bank_count 2.
`timescale 1ns / 1ps

module lru_rom_bank_cache #(
   parameter int SLOTS     = 8,
   parameter int BANK_BITS = 9
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // tdata: bank_request[BANK_BITS-1:0], zero pad
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((BANK_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // tdata: resolved_bank, is_fixed_bank, hit, slot_index, fetch_needed,
   //        hit_total[31:0], miss_total[31:0], zero pad
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((BANK_BITS + (SLOTS > 1 ? $clog2(SLOTS) : 1) + 3 + 2 * lrc_pkg::TOTAL_W
                   + 7) / 8) * 8 - 1:0]            rsp_tdata,
   input  logic                                   csr_wen,
   input  logic [lrc_pkg::CSR_W-1:0]              csr_wdata
);

   import lrc_pkg::*;

   localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int RAM_W   = BANK_BITS + STAMP_W;
   localparam int RSP_USE = BANK_BITS + IDX_W + 3 + 2 * TOTAL_W;
   localparam int RSP_W   = ((RSP_USE + 7) / 8) * 8;
   localparam int MASK_W  = (BANK_BITS > CSR_W) ? BANK_BITS : CSR_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIXED,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE
   } state_type;

   state_type            state_ff, state_in;
   logic [CSR_W-1:0]     bank_count_ff, bank_count_in;
   logic [BANK_BITS-1:0] bank_ff, bank_in;
   logic [IDX_W-1:0]     rd_cnt_ff, rd_cnt_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [SLOTS-1:0]     valid_ff, valid_in;
   logic [STAMP_W-1:0]   use_clock_ff, use_clock_in;
   logic [TOTAL_W-1:0]   hit_cnt_ff, hit_cnt_in;
   logic [TOTAL_W-1:0]   miss_cnt_ff, miss_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]     rsp_data_ff, rsp_data_in;

   logic                 req_take;
   logic                 out_free;
   logic [CSR_W-1:0]     count_m1;
   logic [MASK_W-1:0]    bank_mask;
   logic [BANK_BITS-1:0] resolved;
   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic [RAM_W-1:0]     ram_wdata;
   logic                 ram_re;
   logic [RAM_W-1:0]     ram_rdata;
   lrc_scan_ctrl_type    scan_ctrl;
   logic                 scan_found;
   logic [IDX_W-1:0]     scan_found_idx;
   logic [IDX_W-1:0]     scan_victim_idx;
   logic [IDX_W-1:0]     target_idx;
   logic [STAMP_W-1:0]   clock_next;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // a bank count of zero leaves the request unmasked
   assign count_m1  = bank_count_ff - CSR_W'(1);
   assign bank_mask = (bank_count_ff == '0) ? '1 : MASK_W'(count_m1);
   assign resolved  = req_tdata[BANK_BITS-1:0] & bank_mask[BANK_BITS-1:0];

   assign target_idx = scan_found ? scan_found_idx : scan_victim_idx;
   assign clock_next = use_clock_ff + STAMP_W'(1);

   assign ram_re    = (state_ff == ST_SCAN);
   assign ram_we    = (state_ff == ST_UPDATE) && out_free;
   assign ram_waddr = target_idx;
   assign ram_wdata = {bank_ff, clock_next};

   assign scan_ctrl.clear  = req_take;
   assign scan_ctrl.sample = rd_pend_ff;

   lrc_ram #(
      .WIDTH (RAM_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rd_cnt_ff),
      .rd_data (ram_rdata)
   );

   lrc_scan #(
      .BANK_BITS (BANK_BITS),
      .IDX_W     (IDX_W)
   ) u_scan (
      .clock       (clock),
      .ctrl        (scan_ctrl),
      .bank        (bank_ff),
      .entry_idx   (rd_idx_ff),
      .entry_valid (valid_ff[rd_idx_ff]),
      .entry_tag   (ram_rdata[RAM_W-1:STAMP_W]),
      .entry_stamp (ram_rdata[STAMP_W-1:0]),
      .found       (scan_found),
      .found_idx   (scan_found_idx),
      .victim_idx  (scan_victim_idx)
   );

   always_comb begin
      state_in      = state_ff;
      bank_count_in = csr_wen ? csr_wdata : bank_count_ff;
      bank_in       = bank_ff;
      rd_cnt_in     = rd_cnt_ff;
      rd_pend_in    = ram_re;
      rd_idx_in     = rd_cnt_ff;
      valid_in      = valid_ff;
      use_clock_in  = use_clock_ff;
      hit_cnt_in    = hit_cnt_ff;
      miss_cnt_in   = miss_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               bank_in   = resolved;
               rd_cnt_in = '0;
               state_in  = (resolved == '0) ? ST_FIXED : ST_SCAN;
            end
         end
         ST_FIXED: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({miss_cnt_ff, hit_cnt_ff, 1'b0, IDX_W'(0),
                                      1'b0, 1'b1, bank_ff});
               state_in     = ST_IDLE;
            end
         end
         ST_SCAN: begin
            rd_cnt_in = rd_cnt_ff + IDX_W'(1);
            if (rd_cnt_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last slot entry is sampled by the scan unit this cycle
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               valid_in[target_idx] = 1'b1;
               use_clock_in = clock_next;
               if (scan_found) begin
                  hit_cnt_in = hit_cnt_ff + TOTAL_W'(1);
               end else begin
                  miss_cnt_in = miss_cnt_ff + TOTAL_W'(1);
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({miss_cnt_in, hit_cnt_in, !scan_found, target_idx,
                                      scan_found, 1'b0, bank_ff});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bank_count_ff <= CSR_RESET;
         rd_cnt_ff     <= '0;
         rd_pend_ff    <= 1'b0;
         valid_ff      <= '0;
         use_clock_ff  <= '0;
         hit_cnt_ff    <= '0;
         miss_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bank_count_ff <= bank_count_in;
         rd_cnt_ff     <= rd_cnt_in;
         rd_pend_ff    <= rd_pend_in;
         valid_ff      <= valid_in;
         use_clock_ff  <= use_clock_in;
         hit_cnt_ff    <= hit_cnt_in;
         miss_cnt_ff   <= miss_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      bank_ff     <= bank_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
